@@ design/hsvr_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvr_pkg
// Shared types, segment codes and the 8-bit scaling helper for the rainbow
// HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsvr_pkg;

  // Rainbow segments, picked by hue[7:5]
  localparam logic [2:0] SEG_RED     = 3'd0;
  localparam logic [2:0] SEG_ORANGE  = 3'd1;
  localparam logic [2:0] SEG_YELLOW  = 3'd2;
  localparam logic [2:0] SEG_GREEN   = 3'd3;
  localparam logic [2:0] SEG_AQUA    = 3'd4;
  localparam logic [2:0] SEG_BLUE    = 3'd5;
  localparam logic [2:0] SEG_PURPLE  = 3'd6;
  localparam logic [2:0] SEG_PINK    = 3'd7;

  localparam logic [7:0] LVL_THIRD     = 8'd85;
  localparam logic [7:0] LVL_TWO_THIRD = 8'd170;
  localparam logic [7:0] LVL_171       = 8'd171;
  localparam logic [7:0] LVL_FULL      = 8'd255;
  localparam logic [4:0] OFF_MASK      = 5'h1F;

  // After stage one: segment, offset terms, saturation, brightness and the desaturation floor
  typedef struct packed {
    logic [2:0] seg;
    logic [7:0] t1;
    logic [7:0] t2;
    logic [7:0] sat;
    logic [7:0] bright;
    logic [7:0] floor8;
  } hsvr_s1_t;

  // After stage two: saturation-scaled channels, brightness and the desaturation floor
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] bright;
    logic [7:0] floor8;
  } hsvr_s2_t;

  // (a * (1 + b)) >> 8; the product never passes 16 bits
  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0]  bp1;
    logic [16:0] prod;
    bp1  = {1'b0, b} + 9'd1;
    prod = {9'd0, a} * {8'd0, bp1};
    return prod[15:8];
  endfunction

endpackage

@@ design/hsvr_seg.sv @@
// ----------------------------------------------------------------------------
// hsvr_seg
// Stage one: segment decode, one-third and two-thirds offset terms, and the
// desaturation floor.
// ----------------------------------------------------------------------------
module hsvr_seg import hsvr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       in_valid,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       out_valid,
  output hsvr_s1_t   out_data
);

  logic [7:0] off;
  logic [7:0] desat;
  hsvr_s1_t   data_next;

  assign off   = {hue[4:0] & OFF_MASK, 3'b000};
  assign desat = LVL_FULL - saturation;

  always_comb begin
    data_next.seg    = hue[7:5];
    data_next.t1     = scale8(off, LVL_THIRD);
    data_next.t2     = scale8(off, LVL_TWO_THIRD);
    data_next.sat    = saturation;
    data_next.bright = brightness;
    data_next.floor8 = scale8(desat, desat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

@@ design/hsvr_sat.sv @@
// ----------------------------------------------------------------------------
// hsvr_sat
// Stage two: raw channel levels per segment, each scaled by saturation.
// ----------------------------------------------------------------------------
module hsvr_sat import hsvr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     in_valid,
  input  hsvr_s1_t in_data,
  output logic     out_valid,
  output hsvr_s2_t out_data
);

  logic [7:0] raw_r;
  logic [7:0] raw_g;
  logic [7:0] raw_b;
  hsvr_s2_t   data_next;

  always_comb begin
    raw_r = 8'd0;
    raw_g = 8'd0;
    raw_b = 8'd0;
    case (in_data.seg)
      SEG_RED: begin
        raw_r = LVL_FULL - in_data.t1;
        raw_g = in_data.t1;
      end
      SEG_ORANGE: begin
        raw_r = LVL_171;
        raw_g = LVL_THIRD + in_data.t1;
      end
      SEG_YELLOW: begin
        raw_r = LVL_171 - in_data.t2;
        raw_g = LVL_TWO_THIRD + in_data.t1;
      end
      SEG_GREEN: begin
        raw_g = LVL_FULL - in_data.t1;
        raw_b = in_data.t1;
      end
      SEG_AQUA: begin
        raw_g = LVL_171 - in_data.t2;
        raw_b = LVL_THIRD + in_data.t2;
      end
      SEG_BLUE: begin
        raw_r = in_data.t1;
        raw_b = LVL_FULL - in_data.t1;
      end
      SEG_PURPLE: begin
        raw_r = LVL_THIRD + in_data.t1;
        raw_b = LVL_171 - in_data.t1;
      end
      default: begin
        raw_r = LVL_TWO_THIRD + in_data.t1;
        raw_b = LVL_THIRD - in_data.t1;
      end
    endcase
  end

  always_comb begin
    data_next.r      = scale8(raw_r, in_data.sat);
    data_next.g      = scale8(raw_g, in_data.sat);
    data_next.b      = scale8(raw_b, in_data.sat);
    data_next.bright = in_data.bright;
    data_next.floor8 = in_data.floor8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

@@ design/hsvr_val.sv @@
// ----------------------------------------------------------------------------
// hsvr_val
// Stage three: add the desaturation floor with saturation at full scale,
// then scale each channel by brightness. Output register of the block.
// ----------------------------------------------------------------------------
module hsvr_val import hsvr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       in_valid,
  input  hsvr_s2_t   in_data,
  output logic       out_valid,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  function automatic logic [7:0] add_sat(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[8] ? LVL_FULL : sum[7:0];
  endfunction

  logic [7:0] r_next;
  logic [7:0] g_next;
  logic [7:0] b_next;

  assign r_next = scale8(add_sat(in_data.r, in_data.floor8), in_data.bright);
  assign g_next = scale8(add_sat(in_data.g, in_data.floor8), in_data.bright);
  assign b_next = scale8(add_sat(in_data.b, in_data.floor8), in_data.bright);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      red   <= r_next;
      green <= g_next;
      blue  <= b_next;
    end
  end

endmodule

@@ design/hsv_rainbow_to_rgb.sv @@
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb
// Rainbow-style 8-bit HSV to RGB converter, three-stage pipeline.
// ----------------------------------------------------------------------------
// Converts one hue/saturation/brightness item per clock while hsv_stall is low
// into red, green and blue. An accepted item moves through the stage one,
// stage two and output registers in that order. The three stages are
// offset/floor terms, segment levels scaled by saturation, and floor add
// scaled by brightness; each holds one item. A stage takes a new item whenever
// it is empty or its contents move on, so hsv_stall rises only when all three
// stages are full and rgb_stall is high. hsv_stall follows rgb_stall
// combinationally.
module hsv_rainbow_to_rgb import hsvr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       hsv_valid,
  output logic       hsv_stall,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       rgb_valid,
  input  logic       rgb_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic     v1;
  logic     v2;
  logic     rdy1;
  logic     rdy2;
  logic     rdy3;
  hsvr_s1_t s1;
  hsvr_s2_t s2;

  assign rdy3      = !rgb_valid || !rgb_stall;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign hsv_stall = !rdy1;

  hsvr_seg u_seg (
    .clk        (clk),
    .rst        (rst),
    .adv        (rdy1),
    .in_valid   (hsv_valid),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (v1),
    .out_data   (s1)
  );

  hsvr_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .adv       (rdy2),
    .in_valid  (v1),
    .in_data   (s1),
    .out_valid (v2),
    .out_data  (s2)
  );

  hsvr_val u_val (
    .clk       (clk),
    .rst       (rst),
    .adv       (rdy3),
    .in_valid  (v2),
    .in_data   (s2),
    .out_valid (rgb_valid),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  // input backs up only with a full pipe behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    hsv_stall |-> (v1 && v2 && rgb_valid && rgb_stall))
    else $error("input stalled with room in the pipe");

  // an item in stage two reaches the output when stage three can take it
  a_s2_moves: assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3) |=> rgb_valid)
    else $error("stage two item lost");

  // full saturation leaves no floor
  a_no_floor: assert property (@(posedge clk) disable iff (rst)
    (v1 && s1.sat == LVL_FULL) |-> (s1.floor8 == 8'd0))
    else $error("floor nonzero at full saturation");

  // a stalled stage two keeps its item
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !rdy3) |=> (v2 && $stable(s2)))
    else $error("stage two changed while blocked");

endmodule
